// ----- design/fmart_pkg.sv -----
// ----------------------------------------------------------------------------
// fmart_pkg
// Types and constants shared by the first-match address rule table.
// ----------------------------------------------------------------------------
package fmart_pkg;

    localparam int ACTION_W     = 2;
    localparam int ADDRESS_W    = 64;
    localparam int CODE_W       = 8;
    localparam int VALUE_W      = 64;
    localparam int HIT_SLOT_W   = 4;
    localparam int STATUS_W     = 2;
    localparam int RULES_HELD_W = 5;
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CODE_W-1:0] HOOK_IP       = 8'd1;
    localparam logic [CODE_W-1:0] OP_EQ         = 8'd1;
    localparam logic [CODE_W-1:0] OP_GT         = 8'd2;
    localparam logic [CODE_W-1:0] OP_LT         = 8'd3;
    localparam logic [CODE_W-1:0] OP_MASK       = 8'd4;
    localparam logic [CODE_W-1:0] VERDICT_BLOCK = 8'd1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

    localparam logic [APB_ADDR_W-1:0] REG_ENABLE_ADDR = 2'd0;

    typedef struct packed {
        logic [CODE_W-1:0]  hook;
        logic [CODE_W-1:0]  operator_code;
        logic [VALUE_W-1:0] value;
        logic [CODE_W-1:0]  verdict;
    } t_rule;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    function automatic logic rule_holds(input t_rule r, input logic [ADDRESS_W-1:0] a);
        logic ok;
        ok = 1'b0;
        if (r.hook == HOOK_IP) begin
            case (r.operator_code)
                OP_EQ:   ok = (a == r.value);
                OP_GT:   ok = (a > r.value);
                OP_LT:   ok = (a < r.value);
                OP_MASK: ok = ((a & r.value) == r.value);
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

// ----- design/fmart_if.sv -----
// ----------------------------------------------------------------------------
// fmart_in_if / fmart_out_if
// Valid/ready channels that carry request beats and result beats.
// ----------------------------------------------------------------------------
interface fmart_in_if import fmart_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [ADDRESS_W-1:0] address;
    logic [CODE_W-1:0]    new_hook;
    logic [CODE_W-1:0]    new_operator;
    logic [VALUE_W-1:0]   new_value;
    logic [CODE_W-1:0]    new_verdict;

    modport source (
        output valid, action, address, new_hook, new_operator, new_value, new_verdict,
        input  ready
    );
    modport sink (
        input  valid, action, address, new_hook, new_operator, new_value, new_verdict,
        output ready
    );
endinterface

interface fmart_out_if import fmart_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    deny;
    logic                    hit;
    logic [HIT_SLOT_W-1:0]   hit_slot;
    logic [STATUS_W-1:0]     status;
    logic [RULES_HELD_W-1:0] rules_held;

    modport source (
        output valid, deny, hit, hit_slot, status, rules_held,
        input  ready
    );
    modport sink (
        input  valid, deny, hit, hit_slot, status, rules_held,
        output ready
    );
endinterface

// ----- design/fmart_ram.sv -----
// ----------------------------------------------------------------------------
// fmart_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fmart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/first_match_address_rule_table.sv -----
// ----------------------------------------------------------------------------
// first_match_address_rule_table
// Rule table that classifies addresses by the first matching IP-hook rule and
// accepts rule appends and table clears.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Beat contents
// i_in     in   valid/ready        action, address, new rule fields
// o_out    out  valid/ready        deny, hit, hit_slot, status, rules_held
// apb      in   psel/penable/pwrite enable register at byte address 0
//
// A check or add reads one rule per cycle; its result is registered once the
// scan passes the last filled slot, or when it stops at a matching or
// duplicate slot. A disabled check, an add to a full table, a clear or an
// unused action skips the scan.
// One request is in flight at a time; the next is taken the cycle after the
// result is registered, also while that result waits.
// A stalled result holds the sequencer before the table is updated.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module first_match_address_rule_table import fmart_pkg::*; #(
    parameter int RULE_SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fmart_in_if.sink              i_in,
    fmart_out_if.source           o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);
    localparam int RULE_W = $bits(t_rule);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(RULE_SLOTS);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic                  r_enable;
    logic [ACTION_W-1:0]   r_act, n_act;
    logic [ADDRESS_W-1:0]  r_addr, n_addr;
    t_rule                 r_new, n_new;
    logic [CNT_W-1:0]      r_rd_cnt, n_rd_cnt;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_pend_deny, n_pend_deny;
    logic                  r_pend_hit, n_pend_hit;
    logic [IDX_W-1:0]      r_pend_slot, n_pend_slot;
    logic [STATUS_W-1:0]   r_pend_status, n_pend_status;
    logic                  r_pend_write, n_pend_write;
    logic                  r_out_valid, n_out_valid;
    logic                  r_deny, n_deny;
    logic                  r_hit, n_hit;
    logic [HIT_SLOT_W-1:0] r_hit_slot, n_hit_slot;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [RULES_HELD_W-1:0] r_rules_held, n_rules_held;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [IDX_W-1:0]      ram_raddr;
    logic [RULE_W-1:0]     ram_rdata;
    t_rule                 rd_rule;
    logic                  issue;
    logic                  matched;
    logic                  in_acc;
    logic                  out_free;

    fmart_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_rule  = t_rule'(ram_rdata);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign issue    = (r_state == S_SCAN) && (r_rd_cnt < r_fill);
    assign ram_raddr = r_rd_cnt[IDX_W-1:0];
    assign ram_waddr = r_fill[IDX_W-1:0];
    assign matched  = (r_act == ACT_CHECK) ? rule_holds(rd_rule, r_addr)
                                           : (rd_rule == r_new);

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.deny       = r_deny;
    assign o_out.hit        = r_hit;
    assign o_out.hit_slot   = r_hit_slot;
    assign o_out.status     = r_status;
    assign o_out.rules_held = r_rules_held;

    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(r_enable);

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_act         = r_act;
        n_addr        = r_addr;
        n_new         = r_new;
        n_rd_cnt      = r_rd_cnt;
        n_cmp_vld     = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        n_pend_deny   = r_pend_deny;
        n_pend_hit    = r_pend_hit;
        n_pend_slot   = r_pend_slot;
        n_pend_status = r_pend_status;
        n_pend_write  = r_pend_write;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_deny        = r_deny;
        n_hit         = r_hit;
        n_hit_slot    = r_hit_slot;
        n_status      = r_status;
        n_rules_held  = r_rules_held;
        ram_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_act         = i_in.action;
                    n_addr        = i_in.address;
                    n_new.hook          = i_in.new_hook;
                    n_new.operator_code = i_in.new_operator;
                    n_new.value         = i_in.new_value;
                    n_new.verdict       = i_in.new_verdict;
                    n_rd_cnt      = '0;
                    n_pend_deny   = 1'b0;
                    n_pend_hit    = 1'b0;
                    n_pend_slot   = '0;
                    n_pend_status = ST_OK;
                    n_pend_write  = 1'b0;
                    n_state       = S_DONE;
                    if (i_in.action == ACT_CHECK && r_enable) begin
                        n_state = S_SCAN;
                    end else if (i_in.action == ACT_ADD) begin
                        if (r_fill >= SLOTS_CNT) begin
                            n_pend_status = ST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = issue;
                n_cmp_idx = r_rd_cnt[IDX_W-1:0];
                n_rd_cnt  = r_rd_cnt + CNT_W'(issue);
                if (r_cmp_vld && matched) begin
                    n_state = S_DONE;
                    if (r_act == ACT_CHECK) begin
                        n_pend_hit  = 1'b1;
                        n_pend_slot = r_cmp_idx;
                        n_pend_deny = (rd_rule.verdict == VERDICT_BLOCK);
                    end else begin
                        n_pend_status = ST_DUP;
                    end
                end else if (!r_cmp_vld && !issue) begin
                    n_state      = S_DONE;
                    n_pend_write = (r_act == ACT_ADD);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ram_we = r_pend_write;
                    if (r_pend_write) begin
                        n_fill = r_fill + CNT_W'(1);
                    end else if (r_act == ACT_CLEAR) begin
                        n_fill = '0;
                    end
                    n_out_valid  = 1'b1;
                    n_deny       = r_pend_deny;
                    n_hit        = r_pend_hit;
                    n_hit_slot   = HIT_SLOT_W'(r_pend_slot);
                    n_status     = r_pend_status;
                    n_rules_held = RULES_HELD_W'(n_fill);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_enable    <= 1'b1;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && paddr == REG_ENABLE_ADDR) begin
                r_enable <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act         <= n_act;
        r_addr        <= n_addr;
        r_new         <= n_new;
        r_rd_cnt      <= n_rd_cnt;
        r_cmp_idx     <= n_cmp_idx;
        r_pend_deny   <= n_pend_deny;
        r_pend_hit    <= n_pend_hit;
        r_pend_slot   <= n_pend_slot;
        r_pend_status <= n_pend_status;
        r_pend_write  <= n_pend_write;
        r_deny        <= n_deny;
        r_hit         <= n_hit;
        r_hit_slot    <= n_hit_slot;
        r_status      <= n_status;
        r_rules_held  <= n_rules_held;
    end

endmodule

// ----- design/fmart_checker.sv -----
// ----------------------------------------------------------------------------
// fmart_checker
// Port-level checks on the rule table's request and result beats.
// ----------------------------------------------------------------------------
module fmart_checker import fmart_pkg::*; #(
    parameter int RULE_SLOTS = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic                    i_out_deny,
    input logic                    i_out_hit,
    input logic [HIT_SLOT_W-1:0]   i_out_hit_slot,
    input logic [STATUS_W-1:0]     i_out_status,
    input logic [RULES_HELD_W-1:0] i_out_rules_held
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result beat dropped while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Request taken while the previous one is still in work.");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (32'(i_out_rules_held) <= RULE_SLOTS || RULE_SLOTS > 31))
        else $error("Rule count exceeds the table size.");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_hit |-> i_out_status == ST_OK)
        else $error("A matching check reported an add status.");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> !i_out_deny && i_out_hit_slot == '0)
        else $error("Deny or slot set without a match.");

endmodule

bind first_match_address_rule_table fmart_checker #(
    .RULE_SLOTS (RULE_SLOTS)
) u_fmart_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_deny       (o_out.deny),
    .i_out_hit        (o_out.hit),
    .i_out_hit_slot   (o_out.hit_slot),
    .i_out_status     (o_out.status),
    .i_out_rules_held (o_out.rules_held)
);
